// File: hw/rtl/distance_pid_controller_top_assert.svh
// Assertion macros for the distance PID controller checker.
// Expects clk and arst_n in the scope of the module that uses them.
`ifndef DISTANCE_PID_CONTROLLER_TOP_ASSERT_SVH
`define DISTANCE_PID_CONTROLLER_TOP_ASSERT_SVH

// Consequent checked in the cycle after the antecedent.
`define DPID_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

// Consequent checked in the same cycle as the antecedent.
`define DPID_ASSERT_SAME(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

// File: hw/rtl/dpid_pkg.sv
// Shared types, constants and helper functions for the distance PID controller.
// No dependencies; used by dpid_ctrl, dpid_datapath, the top level and the bench.
`default_nettype none

package dpid_pkg;

	localparam int DATA_W    = 32;
	localparam int GAIN_W    = 31;
	localparam int WLEN_W    = 8;
	localparam int CFG_IDX_W = 3;
	localparam int FRAC_W    = 16;
	localparam int TGT_SHIFT = 18;
	localparam int MUL_W     = 33;
	localparam int PROD_W    = 64;
	localparam int DMAG_W    = 23;
	localparam int DIFF_W    = 20;
	localparam int DIV_SHIFT = 28;
	localparam int DIFF_LIMIT = 327680;

	localparam logic signed [PROD_W-1:0] TARGET_BASE = 64'sd1966080;
	localparam logic signed [DATA_W-1:0] SAT_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [DATA_W-1:0] SAT_MIN = 32'sh8000_0000;

	localparam logic [CFG_IDX_W-1:0] REG_KP      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_KI_DT   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_KD_DT   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_OUT_MAX = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_OUT_MIN = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_WIN_LEN = 3'd5;

	localparam logic [GAIN_W-1:0]        KP_RST      = 31'd3277;
	localparam logic [GAIN_W-1:0]        KI_DT_RST   = 31'd13;
	localparam logic [GAIN_W-1:0]        KD_DT_RST   = 31'd163840;
	localparam logic signed [DATA_W-1:0] OUT_MAX_RST = 32'sd327680;
	localparam logic signed [DATA_W-1:0] OUT_MIN_RST = -32'sd327680;
	localparam logic [WLEN_W-1:0]        WIN_LEN_RST = 8'd100;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_TGT_MUL,
		ST_TGT_SAT,
		ST_ERR,
		ST_P_MUL,
		ST_P_CLAMP,
		ST_DIV_MUL,
		ST_DIV_FIX,
		ST_D_MUL,
		ST_D_CLAMP,
		ST_DROP_RD,
		ST_DROP_SUB,
		ST_RING_WR,
		ST_ILO_MUL,
		ST_IHI_MUL,
		ST_I_ADD,
		ST_I_CLAMP,
		ST_OUT
	} state_t;

	typedef enum logic [4:0] {
		OP_NONE,
		OP_LOAD,
		OP_TGT_MUL,
		OP_TGT_SAT,
		OP_ERR,
		OP_P_MUL,
		OP_P_CLAMP,
		OP_DIV_MUL,
		OP_DIV_FIX,
		OP_D_MUL,
		OP_D_CLAMP,
		OP_DROP_RD,
		OP_DROP_SUB,
		OP_RING_WR,
		OP_ILO_MUL,
		OP_IHI_MUL,
		OP_I_ADD,
		OP_I_CLAMP,
		OP_OUT_LOAD
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
	} dp_cmd_t;

	typedef struct packed {
		logic drop_req;
	} dp_status_t;

	function automatic logic signed [DATA_W-1:0] sat32(input logic signed [PROD_W-1:0] x);
		logic signed [DATA_W-1:0] r;
		if (x > PROD_W'(SAT_MAX))
			r = SAT_MAX;
		else if (x < PROD_W'(SAT_MIN))
			r = SAT_MIN;
		else
			r = x[DATA_W-1:0];
		return r;
	endfunction

	// above hi wins over below lo when the bounds cross
	function automatic logic signed [DATA_W-1:0] clamp_out(
		input logic signed [PROD_W-1:0] v,
		input logic signed [DATA_W-1:0] lo,
		input logic signed [DATA_W-1:0] hi
	);
		logic signed [DATA_W-1:0] r;
		if (v > PROD_W'(hi))
			r = hi;
		else if (v < PROD_W'(lo))
			r = lo;
		else
			r = v[DATA_W-1:0];
		return r;
	endfunction

endpackage

`default_nettype wire

// File: hw/rtl/dpid_ctrl.sv
// Sequencer for the distance PID controller: walks one item through the datapath.
// Depends on dpid_pkg for the state, command and status types.
`default_nettype none

module dpid_ctrl (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   in_valid,
	output logic                  in_ready,
	output logic                  out_valid,
	input  wire                   out_ready,
	output dpid_pkg::dp_cmd_t     cmd,
	input  dpid_pkg::dp_status_t  status
);
	import dpid_pkg::*;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;
	logic   out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:     if (in_valid) state_d = ST_TGT_MUL;
			ST_TGT_MUL:  state_d = ST_TGT_SAT;
			ST_TGT_SAT:  state_d = ST_ERR;
			ST_ERR:      state_d = ST_P_MUL;
			ST_P_MUL:    state_d = ST_P_CLAMP;
			ST_P_CLAMP:  state_d = ST_DIV_MUL;
			ST_DIV_MUL:  state_d = ST_DIV_FIX;
			ST_DIV_FIX:  state_d = ST_D_MUL;
			ST_D_MUL:    state_d = ST_D_CLAMP;
			ST_D_CLAMP:  state_d = status.drop_req ? ST_DROP_RD : ST_RING_WR;
			ST_DROP_RD:  state_d = ST_DROP_SUB;
			ST_DROP_SUB: state_d = status.drop_req ? ST_DROP_RD : ST_RING_WR;
			ST_RING_WR:  state_d = ST_ILO_MUL;
			ST_ILO_MUL:  state_d = ST_IHI_MUL;
			ST_IHI_MUL:  state_d = ST_I_ADD;
			ST_I_ADD:    state_d = ST_I_CLAMP;
			ST_I_CLAMP:  state_d = ST_OUT;
			ST_OUT:      if (out_free) state_d = ST_IDLE;
			default:     state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready = 1'b0;
		cmd.op   = OP_NONE;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) cmd.op = OP_LOAD;
			end
			ST_TGT_MUL:  cmd.op = OP_TGT_MUL;
			ST_TGT_SAT:  cmd.op = OP_TGT_SAT;
			ST_ERR:      cmd.op = OP_ERR;
			ST_P_MUL:    cmd.op = OP_P_MUL;
			ST_P_CLAMP:  cmd.op = OP_P_CLAMP;
			ST_DIV_MUL:  cmd.op = OP_DIV_MUL;
			ST_DIV_FIX:  cmd.op = OP_DIV_FIX;
			ST_D_MUL:    cmd.op = OP_D_MUL;
			ST_D_CLAMP:  cmd.op = OP_D_CLAMP;
			ST_DROP_RD:  cmd.op = OP_DROP_RD;
			ST_DROP_SUB: cmd.op = OP_DROP_SUB;
			ST_RING_WR:  cmd.op = OP_RING_WR;
			ST_ILO_MUL:  cmd.op = OP_ILO_MUL;
			ST_IHI_MUL:  cmd.op = OP_IHI_MUL;
			ST_I_ADD:    cmd.op = OP_I_ADD;
			ST_I_CLAMP:  cmd.op = OP_I_CLAMP;
			ST_OUT:      if (out_free) cmd.op = OP_OUT_LOAD;
			default:     cmd.op = OP_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_OUT && out_free)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

endmodule

`default_nettype wire

// File: hw/rtl/dpid_datapath.sv
// Datapath of the distance PID controller: config registers, shared multiplier,
// error ring memory, derivative history and result registers. Uses dpid_pkg.
`default_nettype none

module dpid_datapath #(
	parameter int WINDOW_MAX = 128,
	parameter int DERIV_HALF = 5
) (
	input  wire                                    clk,
	input  wire                                    arst_n,
	input  dpid_pkg::dp_cmd_t                      cmd,
	output dpid_pkg::dp_status_t                   status,
	input  wire                                    cfg_valid,
	input  wire [dpid_pkg::CFG_IDX_W-1:0]          cfg_index,
	input  wire [dpid_pkg::DATA_W-1:0]             cfg_data,
	input  wire signed [dpid_pkg::DATA_W-1:0]      distance,
	input  wire signed [dpid_pkg::DATA_W-1:0]      object_speed,
	input  wire signed [dpid_pkg::DATA_W-1:0]      safety_factor,
	output logic signed [dpid_pkg::DATA_W-1:0]     drive_out,
	output logic signed [dpid_pkg::DATA_W-1:0]     p_term,
	output logic signed [dpid_pkg::DATA_W-1:0]     i_term,
	output logic signed [dpid_pkg::DATA_W-1:0]     d_term
);
	import dpid_pkg::*;

	localparam int CNT_W       = $clog2(WINDOW_MAX + 1);
	localparam int HEAD_W      = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
	localparam int WS_W        = DATA_W + $clog2(WINDOW_MAX);
	localparam int HS_W        = DATA_W + $clog2(DERIV_HALF);
	localparam int HIST_D      = 2 * DERIV_HALF;
	localparam int FILL_W      = $clog2(HIST_D);
	localparam int DERIV_START = HIST_D - 2;
	localparam int DIFF_THRESH = DERIV_HALF * (DIFF_LIMIT + 1);
	localparam logic [DIV_SHIFT:0] DIV_MULT =
		(DIV_SHIFT + 1)'(((1 << DIV_SHIFT) + DERIV_HALF - 1) / DERIV_HALF);

	// configuration
	logic [GAIN_W-1:0]        kp_q;
	logic [GAIN_W-1:0]        ki_dt_q;
	logic [GAIN_W-1:0]        kd_dt_q;
	logic signed [DATA_W-1:0] out_max_q;
	logic signed [DATA_W-1:0] out_min_q;
	logic [WLEN_W-1:0]        window_length_q;

	// item working registers
	logic signed [DATA_W-1:0] dist_q;
	logic signed [DATA_W-1:0] speed_q;
	logic signed [DATA_W-1:0] factor_q;
	logic signed [PROD_W-1:0] prod_q;
	logic signed [DATA_W-1:0] tgt_q;
	logic signed [DATA_W-1:0] e_q;
	logic signed [DATA_W-1:0] p_q;
	logic signed [DATA_W-1:0] i_q;
	logic signed [DATA_W-1:0] d_q;
	logic signed [PROD_W-1:0] acc_q;
	logic [DMAG_W-1:0]        dmag_q;
	logic                     dneg_q;
	logic                     dok_q;
	logic signed [DIFF_W-1:0] diff_q;
	logic signed [DATA_W-1:0] rdata_q;
	logic signed [DATA_W-1:0] drive_q;
	logic signed [DATA_W-1:0] p_out_q;
	logic signed [DATA_W-1:0] i_out_q;
	logic signed [DATA_W-1:0] d_out_q;

	// persistent state
	logic signed [DATA_W-1:0] ring_mem [WINDOW_MAX];
	logic [CNT_W-1:0]         count_q;
	logic [HEAD_W-1:0]        head_q;
	logic signed [WS_W-1:0]   wsum_q;
	logic signed [DATA_W-1:0] hist_q [HIST_D];
	logic signed [HS_W-1:0]   recent_q;
	logic signed [HS_W-1:0]   older_q;
	logic [FILL_W-1:0]        fill_q;

	// combinational
	logic signed [MUL_W-1:0]   mul_a;
	logic signed [MUL_W-1:0]   mul_b;
	logic signed [2*MUL_W-1:0] mul_full;
	logic signed [PROD_W-1:0]  tgt_wide;
	logic signed [PROD_W-1:0]  err_wide;
	logic signed [PROD_W-1:0]  gain_res;
	logic [CNT_W-1:0]          win;
	logic                      win_nz;
	logic [CNT_W:0]            rd_raw;
	logic [CNT_W:0]            rd_fold;
	logic [HEAD_W-1:0]         rd_addr;
	logic [HEAD_W-1:0]         head_next;
	logic signed [HS_W:0]      dx;
	logic [HS_W:0]             dmag_full;
	logic                      warm;
	logic [DIFF_W-2:0]         div_q;
	logic signed [DIFF_W-1:0]  diff_next;
	logic signed [PROD_W-1:0]  sum_wide;

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (cmd.op)
			OP_TGT_MUL: begin
				mul_a = MUL_W'(speed_q);
				mul_b = MUL_W'(factor_q);
			end
			OP_P_MUL: begin
				mul_a = MUL_W'(e_q);
				mul_b = $signed(MUL_W'(kp_q));
			end
			OP_DIV_MUL: begin
				mul_a = $signed(MUL_W'(dmag_q));
				mul_b = $signed(MUL_W'(DIV_MULT));
			end
			OP_D_MUL: begin
				mul_a = MUL_W'(diff_q);
				mul_b = $signed(MUL_W'(kd_dt_q));
			end
			OP_ILO_MUL: begin
				mul_a = $signed(MUL_W'(wsum_q[FRAC_W-1:0]));
				mul_b = $signed(MUL_W'(ki_dt_q));
			end
			OP_IHI_MUL: begin
				mul_a = MUL_W'(wsum_q >>> FRAC_W);
				mul_b = $signed(MUL_W'(ki_dt_q));
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_full = mul_a * mul_b;
	assign tgt_wide = TARGET_BASE + (prod_q >>> TGT_SHIFT);
	assign err_wide = PROD_W'(tgt_q) - PROD_W'(dist_q);
	assign gain_res = prod_q >>> FRAC_W;
	assign sum_wide = PROD_W'(p_q) + PROD_W'(i_q) + PROD_W'(d_q);

	always_comb begin
		if (32'(window_length_q) > 32'(WINDOW_MAX))
			win = CNT_W'(WINDOW_MAX);
		else
			win = CNT_W'(window_length_q);
	end

	assign win_nz          = (win != '0);
	assign status.drop_req = (count_q > win) || (win_nz && count_q == win);

	// oldest entry sits count places behind the head
	always_comb begin
		rd_raw = (CNT_W + 1)'(head_q) + (CNT_W + 1)'(WINDOW_MAX) - (CNT_W + 1)'(count_q);
		if (rd_raw >= (CNT_W + 1)'(WINDOW_MAX))
			rd_fold = rd_raw - (CNT_W + 1)'(WINDOW_MAX);
		else
			rd_fold = rd_raw;
	end

	assign rd_addr   = rd_fold[HEAD_W-1:0];
	assign head_next = (head_q == HEAD_W'(WINDOW_MAX - 1)) ? '0 : head_q + 1'b1;

	assign dx        = (HS_W + 1)'(recent_q) - (HS_W + 1)'(older_q);
	assign dmag_full = dx[HS_W] ? $unsigned(-dx) : $unsigned(dx);
	assign warm      = (fill_q >= FILL_W'(DERIV_START));
	assign div_q     = prod_q[DIV_SHIFT+DIFF_W-2:DIV_SHIFT];
	assign diff_next = !dok_q ? '0 :
		(dneg_q ? -$signed({1'b0, div_q}) : $signed({1'b0, div_q}));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kp_q            <= KP_RST;
			ki_dt_q         <= KI_DT_RST;
			kd_dt_q         <= KD_DT_RST;
			out_max_q       <= OUT_MAX_RST;
			out_min_q       <= OUT_MIN_RST;
			window_length_q <= WIN_LEN_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_KP:      kp_q            <= cfg_data[GAIN_W-1:0];
				REG_KI_DT:   ki_dt_q         <= cfg_data[GAIN_W-1:0];
				REG_KD_DT:   kd_dt_q         <= cfg_data[GAIN_W-1:0];
				REG_OUT_MAX: out_max_q       <= $signed(cfg_data);
				REG_OUT_MIN: out_min_q       <= $signed(cfg_data);
				REG_WIN_LEN: window_length_q <= cfg_data[WLEN_W-1:0];
				default:     ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			head_q   <= '0;
			wsum_q   <= '0;
			recent_q <= '0;
			older_q  <= '0;
			fill_q   <= '0;
			for (int k = 0; k < HIST_D; k++)
				hist_q[k] <= '0;
		end else begin
			case (cmd.op)
				OP_P_MUL: begin
					recent_q <= recent_q + HS_W'(e_q) - HS_W'(hist_q[DERIV_HALF-1]);
					older_q  <= older_q + HS_W'(hist_q[DERIV_HALF-1])
						- HS_W'(hist_q[HIST_D-1]);
					for (int k = HIST_D - 1; k > 0; k--)
						hist_q[k] <= hist_q[k-1];
					hist_q[0] <= e_q;
					if (fill_q < FILL_W'(DERIV_START))
						fill_q <= fill_q + 1'b1;
				end
				OP_DROP_RD:  count_q <= count_q - 1'b1;
				OP_DROP_SUB: wsum_q  <= wsum_q - WS_W'(rdata_q);
				OP_RING_WR: begin
					if (win_nz) begin
						head_q  <= head_next;
						count_q <= count_q + 1'b1;
						wsum_q  <= wsum_q + WS_W'(e_q);
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.op == OP_RING_WR && win_nz)
			ring_mem[head_q] <= e_q;
	end

	always_ff @(posedge clk) begin
		if (cmd.op == OP_DROP_RD)
			rdata_q <= ring_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		prod_q <= $signed(mul_full[PROD_W-1:0]);
		case (cmd.op)
			OP_LOAD: begin
				dist_q   <= distance;
				speed_q  <= object_speed;
				factor_q <= safety_factor;
			end
			OP_TGT_SAT: tgt_q <= sat32(tgt_wide);
			OP_ERR:     e_q   <= sat32(err_wide);
			OP_P_CLAMP: begin
				p_q    <= clamp_out(gain_res, out_min_q, out_max_q);
				dmag_q <= dmag_full[DMAG_W-1:0];
				dneg_q <= dx[HS_W];
				dok_q  <= warm && (dmag_full < (HS_W + 1)'(DIFF_THRESH));
			end
			OP_DIV_FIX: diff_q <= diff_next;
			OP_D_CLAMP: d_q    <= clamp_out(gain_res, out_min_q, out_max_q);
			OP_IHI_MUL: acc_q  <= gain_res;
			OP_I_ADD:   acc_q  <= acc_q + prod_q;
			OP_I_CLAMP: i_q    <= clamp_out(acc_q, out_min_q, out_max_q);
			OP_OUT_LOAD: begin
				drive_q <= clamp_out(sum_wide, out_min_q, out_max_q);
				p_out_q <= p_q;
				i_out_q <= i_q;
				d_out_q <= d_q;
			end
			default: ;
		endcase
	end

	assign drive_out = drive_q;
	assign p_term    = p_out_q;
	assign i_term    = i_out_q;
	assign d_term    = d_out_q;

endmodule

`default_nettype wire

// File: hw/rtl/distance_pid_controller_top.sv
// Distance PID controller: one Q16.16 control step per input transfer.
// Channels: input (distance, object_speed, safety_factor) and output (drive_out,
// p_term, i_term, d_term), both valid/ready; config write port (cfg_index,
// cfg_data) with cfg_ready always high, to be written only while idle.
// One item is processed at a time through a shared 33x33 multiplier (six products
// per item) and a single-port error ring. out_valid rises once the item has gone
// through all its steps, with a ring read and a subtract step added for each
// entry dropped from the full ring: one per item once the integral window is full,
// more right after the window is shrunk. A new input is taken only after the
// result register loads and the sequencer is back in idle.
// The result register holds its value until the output transfer; a stalled
// receiver lets the next item be accepted and computed, and it then waits at its
// final step until the register frees up.
// Reset restores the default gains, clamps and window, empties the window and
// clears the derivative history; d_term stays zero for the first
// 2*DERIV_HALF-3 results.
`default_nettype none

module distance_pid_controller_top #(
	parameter int WINDOW_MAX = 128,
	parameter int DERIV_HALF = 5
) (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire                                 in_valid,
	output logic                                in_ready,
	input  wire signed [dpid_pkg::DATA_W-1:0]   distance,
	input  wire signed [dpid_pkg::DATA_W-1:0]   object_speed,
	input  wire signed [dpid_pkg::DATA_W-1:0]   safety_factor,
	output logic                                out_valid,
	input  wire                                 out_ready,
	output logic signed [dpid_pkg::DATA_W-1:0]  drive_out,
	output logic signed [dpid_pkg::DATA_W-1:0]  p_term,
	output logic signed [dpid_pkg::DATA_W-1:0]  i_term,
	output logic signed [dpid_pkg::DATA_W-1:0]  d_term,
	input  wire                                 cfg_valid,
	output logic                                cfg_ready,
	input  wire [dpid_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  wire [dpid_pkg::DATA_W-1:0]          cfg_data
);
	import dpid_pkg::*;

	dp_cmd_t    cmd;
	dp_status_t status;

	assign cfg_ready = 1'b1;

	dpid_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd),
		.status    (status)
	);

	dpid_datapath #(
		.WINDOW_MAX (WINDOW_MAX),
		.DERIV_HALF (DERIV_HALF)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.status        (status),
		.cfg_valid     (cfg_valid),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.distance      (distance),
		.object_speed  (object_speed),
		.safety_factor (safety_factor),
		.drive_out     (drive_out),
		.p_term        (p_term),
		.i_term        (i_term),
		.d_term        (d_term)
	);

endmodule

`default_nettype wire

// File: hw/rtl/dpid_checker.sv
// Port-level checker for the distance PID controller, bound to the top level.
// Uses the macros of distance_pid_controller_top_assert.svh.
`default_nettype none
`include "distance_pid_controller_top_assert.svh"

module dpid_checker (
	input wire        clk,
	input wire        arst_n,
	input wire        in_valid,
	input wire        in_ready,
	input wire        out_valid,
	input wire        out_ready,
	input wire [31:0] drive_out,
	input wire [31:0] p_term,
	input wire [31:0] i_term,
	input wire [31:0] d_term
);

	`DPID_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped before transfer")
	`DPID_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(drive_out) && $stable(p_term) && $stable(i_term) && $stable(d_term), "result changed while stalled")
	`DPID_ASSERT_NEXT(a_busy_after_in, in_valid && in_ready, !in_ready, "second input taken during a step")
	`DPID_ASSERT_SAME(a_result_from_step, $rose(out_valid), !$past(in_ready), "result appeared without a step")

endmodule

bind distance_pid_controller_top dpid_checker u_dpid_checker (.*);

`default_nettype wire

// File: bench/pid_bench_pkg.sv
// Scoreboard for the distance PID controller bench: a step predictor with its own
// copy of the gains, clamps, integral ring and derivative history, plus the result check.
// Depends on dpid_pkg for widths, register indexes and reset values.
package pid_bench_pkg;

	import dpid_pkg::*;

	localparam int RING_DEPTH = 128;
	localparam int HIST_HALF  = 5;
	localparam int HIST_LEN   = 2 * HIST_HALF;
	localparam int WARMUP     = 2 * HIST_HALF - 2;
	localparam int REPORT_MAX = 10;

	typedef struct packed {
		logic signed [DATA_W-1:0] drive;
		logic signed [DATA_W-1:0] p;
		logic signed [DATA_W-1:0] i;
		logic signed [DATA_W-1:0] d;
	} pid_result_t;

	class pid_step_scoreboard;
		logic [GAIN_W-1:0]        kp, ki_dt, kd_dt;
		logic signed [DATA_W-1:0] out_max, out_min;
		logic [WLEN_W-1:0]        win_len;
		longint                   err_ring[RING_DEPTH];
		int                       ring_count, ring_head;
		longint                   window_sum;
		longint                   err_hist[HIST_LEN];
		longint                   recent_sum, older_sum;
		int                       fill_count;
		pid_result_t              expected_steps[$];
		int                       mismatches;

		function new();
			kp = KP_RST;
			ki_dt = KI_DT_RST;
			kd_dt = KD_DT_RST;
			out_max = OUT_MAX_RST;
			out_min = OUT_MIN_RST;
			win_len = WIN_LEN_RST;
			foreach (err_ring[k]) err_ring[k] = 0;
			foreach (err_hist[k]) err_hist[k] = 0;
			ring_count = 0;
			ring_head = 0;
			window_sum = 0;
			recent_sum = 0;
			older_sum = 0;
			fill_count = 0;
			mismatches = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] data);
			case (idx)
				REG_KP: kp = data[GAIN_W-1:0];
				REG_KI_DT: ki_dt = data[GAIN_W-1:0];
				REG_KD_DT: kd_dt = data[GAIN_W-1:0];
				REG_OUT_MAX: out_max = data;
				REG_OUT_MIN: out_min = data;
				REG_WIN_LEN: win_len = data[WLEN_W-1:0];
				default: ;
			endcase
		endfunction

		function longint sat32(longint x);
			if (x > longint'(SAT_MAX))
				return longint'(SAT_MAX);
			if (x < longint'(SAT_MIN))
				return longint'(SAT_MIN);
			return x;
		endfunction

		// above out_max wins when the bounds cross
		function longint clamp(longint v);
			if (v > longint'(out_max))
				return longint'(out_max);
			if (v < longint'(out_min))
				return longint'(out_min);
			return v;
		endfunction

		// floor(gain * x / 2^16), exact
		function longint scale(logic [GAIN_W-1:0] g, longint x);
			logic signed [95:0] gs, xs, prod;
			gs = {65'd0, g};
			xs = x;
			prod = gs * xs;
			return longint'(prod >>> FRAC_W);
		endfunction

		function void drop_oldest();
			int idx;
			idx = (ring_head + RING_DEPTH - ring_count) % RING_DEPTH;
			window_sum -= err_ring[idx];
			ring_count--;
		endfunction

		function void predict_step(logic signed [DATA_W-1:0] distance,
				logic signed [DATA_W-1:0] speed, logic signed [DATA_W-1:0] factor);
			longint prod, target, e, p, i, d, diff, total;
			int win;
			pid_result_t r;
			prod = longint'(speed) * longint'(factor);
			target = sat32(TARGET_BASE + (prod >>> TGT_SHIFT));
			e = sat32(target - longint'(distance));
			p = clamp(scale(kp, e));

			win = (win_len > RING_DEPTH) ? RING_DEPTH : int'(win_len);
			while (ring_count > win)
				drop_oldest();
			if (win > 0) begin
				if (ring_count == win)
					drop_oldest();
				err_ring[ring_head] = e;
				ring_head = (ring_head + 1) % RING_DEPTH;
				ring_count++;
				window_sum += e;
			end
			i = clamp(scale(ki_dt, window_sum));

			recent_sum += e - err_hist[HIST_HALF-1];
			older_sum += err_hist[HIST_HALF-1] - err_hist[HIST_LEN-1];
			for (int k = HIST_LEN - 1; k > 0; k--)
				err_hist[k] = err_hist[k-1];
			err_hist[0] = e;
			if (fill_count < WARMUP)
				fill_count++;
			diff = 0;
			if (fill_count >= WARMUP)
				diff = (recent_sum - older_sum) / HIST_HALF;
			if (diff > DIFF_LIMIT || diff < -DIFF_LIMIT)
				diff = 0;
			d = clamp(scale(kd_dt, diff));
			total = clamp(p + i + d);

			r.drive = total[DATA_W-1:0];
			r.p = p[DATA_W-1:0];
			r.i = i[DATA_W-1:0];
			r.d = d[DATA_W-1:0];
			expected_steps.push_back(r);
		endfunction

		function void check_result(logic signed [DATA_W-1:0] drive, logic signed [DATA_W-1:0] p,
				logic signed [DATA_W-1:0] i, logic signed [DATA_W-1:0] d);
			pid_result_t want, got;
			got = {drive, p, i, d};
			if (expected_steps.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_MAX)
					$display("unexpected result: drive_out=%0d p=%0d i=%0d d=%0d",
						drive, p, i, d);
				return;
			end
			want = expected_steps.pop_front();
			if (got !== want) begin
				mismatches++;
				if (mismatches <= REPORT_MAX)
					$display("mismatch: expected drive_out=%0d p=%0d i=%0d d=%0d, got %0d %0d %0d %0d",
						$signed(want.drive), $signed(want.p), $signed(want.i), $signed(want.d),
						drive, p, i, d);
			end
		endfunction

		function int pending();
			return expected_steps.size();
		endfunction
	endclass

endpackage

// File: bench/testbench.sv
// Top of the distance PID controller bench: clock, reset, stimulus, config phases,
// random stalls on both channels, transfer monitor and watchdog.
// Depends on dpid_pkg, pid_bench_pkg and distance_pid_controller_top.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import dpid_pkg::*;
	import pid_bench_pkg::*;

	localparam int WATCHDOG_LIMIT = 5000;
	localparam int SETTLE_CYCLES  = 40;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic signed [DATA_W-1:0] distance = '0;
	logic signed [DATA_W-1:0] object_speed = '0;
	logic signed [DATA_W-1:0] safety_factor = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [DATA_W-1:0] drive_out, p_term, i_term, d_term;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [DATA_W-1:0] cfg_data = '0;

	pid_step_scoreboard sb;
	bit no_stall = 1'b0;
	int quiet_cycles = 0;
	int track_dist = 40 << 16;
	int track_speed = 10 << 16;
	int track_factor = 1 << 16;

	distance_pid_controller_top uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.distance(distance),
		.object_speed(object_speed),
		.safety_factor(safety_factor),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.drive_out(drive_out),
		.p_term(p_term),
		.i_term(i_term),
		.d_term(d_term),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int pick_gap();
		int r;
		if (no_stall)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 20);
		return $urandom_range(30, 100);
	endfunction

	function automatic logic [DATA_W-1:0] corner_value();
		case ($urandom_range(0, 5))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return 32'h0000_0000;
			3: return 32'hFFFF_FFFF;
			4: return 32'h0000_0001;
			default: return $urandom;
		endcase
	endfunction

	task automatic send_item(input logic [DATA_W-1:0] d, input logic [DATA_W-1:0] s,
			input logic [DATA_W-1:0] f);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		distance <= d;
		object_speed <= s;
		safety_factor <= f;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
	endtask

	task automatic send_random_item();
		int kind;
		logic [DATA_W-1:0] d, s, f;
		kind = $urandom_range(0, 99);
		if (kind < 65) begin
			// plausible following traffic, with an occasional jump
			if (kind < 4)
				track_dist = int'($urandom_range(0, 120 << 16));
			else
				track_dist = track_dist + int'($urandom_range(0, 131072)) - 65536;
			track_speed = track_speed + int'($urandom_range(0, 32768)) - 16384;
			track_factor = track_factor + int'($urandom_range(0, 4096)) - 2048;
			if (track_dist < 0 || track_dist > (200 << 16))
				track_dist = 40 << 16;
			if (track_speed < 0 || track_speed > (40 << 16))
				track_speed = 10 << 16;
			if (track_factor < 0 || track_factor > (4 << 16))
				track_factor = 1 << 16;
			d = track_dist;
			s = track_speed;
			f = track_factor;
		end else if (kind < 85) begin
			d = $urandom;
			s = $urandom;
			f = $urandom;
		end else begin
			d = corner_value();
			s = corner_value();
			f = corner_value();
		end
		send_item(d, s, f);
	endtask

	task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	task automatic apply_setting(input logic [DATA_W-1:0] kp, input logic [DATA_W-1:0] ki,
			input logic [DATA_W-1:0] kd, input logic [DATA_W-1:0] omax,
			input logic [DATA_W-1:0] omin, input logic [DATA_W-1:0] win);
		cfg_write(REG_KP, kp);
		cfg_write(REG_KI_DT, ki);
		cfg_write(REG_KD_DT, kd);
		cfg_write(REG_OUT_MAX, omax);
		cfg_write(REG_OUT_MIN, omin);
		cfg_write(REG_WIN_LEN, win);
	endtask

	task automatic random_setting();
		logic [DATA_W-1:0] g[3];
		logic [DATA_W-1:0] omax, omin;
		logic [WLEN_W-1:0] win;
		int r;
		foreach (g[k])
			g[k] = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 1 << 18);
		if ($urandom_range(0, 3) == 0) begin
			omax = $urandom;
			omin = $urandom;
		end else begin
			omax = $urandom_range(1 << 16, 20 << 16);
			omin = -int'($urandom_range(1 << 16, 20 << 16));
		end
		r = $urandom_range(0, 9);
		if (r == 0)
			win = 0;
		else if (r == 1)
			win = $urandom_range(129, 255);
		else if (r == 2)
			win = 128;
		else
			win = $urandom_range(1, 40);
		apply_setting(g[0], g[1], g[2], omax, omin, {8'($urandom), 16'($urandom), win});
	endtask

	// every result in, then let the block go quiet
	task automatic settle();
		in_valid <= 1'b0;
		while (sb.pending() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	initial begin
		int gap;
		forever begin
			@(negedge clk);
			gap = pick_gap();
			if (gap == 0)
				out_ready <= 1'b1;
			else begin
				out_ready <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready)
				sb.predict_step(distance, object_speed, safety_factor);
			if (out_valid && out_ready)
				sb.check_result(drive_out, p_term, i_term, d_term);
			if (cfg_valid && cfg_ready)
				sb.write_reg(cfg_index, cfg_data);
			if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
				quiet_cycles <= 0;
			else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
				$display("simulation failed");
				$finish;
			end else
				quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		int n;
		sb = new();
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: zero, error zero, saturating target and error, floor rounding
		send_item(32'd0, 32'd0, 32'd0);
		send_item(32'd1966080, 32'd0, 32'd0);
		send_item(32'h7FFF_FFFF, 32'd0, 32'd0);
		send_item(32'h8000_0000, 32'd0, 32'd0);
		send_item(32'd0, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
		send_item(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
		send_item(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
		send_item(32'd0, 32'hFFFF_FFFF, 32'd1);
		send_item(32'd35 << 16, 32'd10 << 16, 32'd2 << 16);
		// slow ramp, once the derivative has warmed up
		for (n = 0; n < 8; n++)
			send_item((32'd40 << 16) - n * 32768, 32'd10 << 16, 32'd2 << 16);
		// jumps past the derivative limit, then back
		send_item(32'd0, 32'd10 << 16, 32'd2 << 16);
		send_item(32'd150 << 16, 32'd10 << 16, 32'd2 << 16);
		send_item(32'd36 << 16, 32'd10 << 16, 32'd2 << 16);

		for (int phase = 0; phase < 10; phase++) begin
			if (phase > 0) begin
				settle();
				case (phase)
					1: apply_setting(32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
						32'h7FFF_FFFF, 32'h8000_0000, 32'd128);
					// shrink a full window
					2: apply_setting(32'd65536, 32'd655, 32'd16384,
						32'd10 << 16, -32'sd655360, 32'd3);
					3: apply_setting(32'd0, 32'd0, 32'd0, 32'd5 << 16, -32'sd327680, 32'd0);
					// crossed clamps
					4: apply_setting(32'd32770, 32'(KI_DT_RST), 32'(KD_DT_RST),
						-32'sd131072, 32'd3 << 16, 32'd1);
					5: apply_setting(32'(KP_RST), 32'(KI_DT_RST), 32'(KD_DT_RST),
						32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF);
					6: begin
						cfg_write(REG_SPARE_A, $urandom);
						cfg_write(REG_SPARE_B, $urandom);
						random_setting();
					end
					default: random_setting();
				endcase
			end
			no_stall = (phase % 4 == 3);
			n = (phase == 1) ? 150 : 90;
			repeat (n) send_random_item();
		end
		no_stall = 1'b0;
		settle();

		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

// File: sim.f
+incdir+hw/rtl
hw/rtl/dpid_pkg.sv
hw/rtl/dpid_ctrl.sv
hw/rtl/dpid_datapath.sv
hw/rtl/distance_pid_controller_top.sv
hw/rtl/dpid_checker.sv
bench/pid_bench_pkg.sv
bench/testbench.sv
